// ===== rtl/core/lfu_cache_replacement_unit_macros.svh =====
// Assertion macros for the LFU replacement unit checker.
`ifndef LFU_CACHE_REPLACEMENT_UNIT_MACROS_SVH
`define LFU_CACHE_REPLACEMENT_UNIT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define LFU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define LFU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/lfu_pkg.sv =====
// Package: sizes, types and helpers of the LFU replacement unit.
`default_nettype none
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;

  localparam int KEY_W   = 32;
  localparam int CAP_W   = 5;
  localparam int OCC_OUT_W = 5;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W   = IDX_W;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam int GROUP   = 4;
  localparam int NGROUPS = (ENTRIES + GROUP - 1) / GROUP;

  localparam int IN_DATA_W  = KEY_W;
  localparam int OUT_DATA_W = 3 + KEY_W + OCC_OUT_W;

  localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Output tdata bit positions
  localparam int OUT_HIT_BIT    = 0;
  localparam int OUT_BYPASS_BIT = 1;
  localparam int OUT_EVICT_BIT  = 2;
  localparam int OUT_EKEY_LSB   = 3;
  localparam int OUT_OCC_LSB    = OUT_EKEY_LSB + KEY_W;

  typedef struct packed {
    logic load;    // capture input key
    logic scan;    // key match, free slot, per-group victim
    logic fold;    // final victim across groups
    logic commit;  // apply update, load output register
  } lfu_cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [IDX_W-1:0]      idx;
    logic [COUNT_BITS-1:0] count;
    logic [AGE_W-1:0]      age;
    logic [KEY_W-1:0]      key;
  } cand_t;

  // Keep a unless b is a strictly better victim: valid where a is not, lower count, or same count and older.
  function automatic cand_t pick_victim(input cand_t a, input cand_t b);
    logic take_b;
    take_b = b.valid && (!a.valid || (b.count < a.count) ||
                         ((b.count == a.count) && (b.age > a.age)));
    return take_b ? b : a;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lfu_ctrl.sv =====
// Controller: sequences one access through scan, fold and commit.
`default_nettype none
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lfu_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FOLD,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lfu_datapath.sv =====
// Datapath: directory entries, match/victim search, update and output register.
`default_nettype none
module lfu_datapath
  import lfu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfu_cmd_t              cmd_i,
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  // Directory
  logic                  valid_q [ENTRIES];
  logic [KEY_W-1:0]      key_q   [ENTRIES];
  logic [COUNT_BITS-1:0] count_q [ENTRIES];
  logic [AGE_W-1:0]      age_q   [ENTRIES];
  logic [OCC_W-1:0]      total_q;
  logic [CAP_W-1:0]      cap_q;

  // Per-access working registers
  logic [KEY_W-1:0]      acc_key_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [COUNT_BITS-1:0] hit_count_q;
  logic [AGE_W-1:0]      hit_age_q;
  logic [IDX_W-1:0]      free_idx_q;
  cand_t                 grp_q [NGROUPS];
  cand_t                 victim_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // ---- scan: match, free slot, group victims ----
  logic                  hit_d;
  logic [IDX_W-1:0]      hit_idx_d;
  logic [COUNT_BITS-1:0] hit_count_d;
  logic [AGE_W-1:0]      hit_age_d;
  logic [IDX_W-1:0]      free_idx_d;
  cand_t                 grp_d [NGROUPS];

  always_comb begin
    hit_d       = 1'b0;
    hit_idx_d   = '0;
    hit_count_d = '0;
    hit_age_d   = '0;
    free_idx_d  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (key_q[i] == acc_key_q)) begin
        hit_d       = 1'b1;
        hit_idx_d   = IDX_W'(i);
        hit_count_d = count_q[i];
        hit_age_d   = age_q[i];
      end
      if (!valid_q[i]) begin
        free_idx_d = IDX_W'(i);
      end
    end
  end

  always_comb begin
    cand_t c;
    for (int g = 0; g < NGROUPS; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        c = '0;
        if (g * GROUP + j < ENTRIES) begin
          c.valid = valid_q[g * GROUP + j];
          c.idx   = IDX_W'(g * GROUP + j);
          c.count = count_q[g * GROUP + j];
          c.age   = age_q[g * GROUP + j];
          c.key   = key_q[g * GROUP + j];
        end
        grp_d[g] = pick_victim(grp_d[g], c);
      end
    end
  end

  // ---- fold: one victim across groups ----
  cand_t victim_d;

  always_comb begin
    victim_d = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      victim_d = pick_victim(victim_d, grp_q[g]);
    end
  end

  // ---- commit ----
  logic [CMP_W-1:0] cap_ext, cap_eff, total_ext;
  logic             bypass, need_evict, age_all;
  logic [IDX_W-1:0] slot;
  logic [AGE_W-1:0] old_age;
  logic [OCC_W-1:0] total_d;
  logic [KEY_W-1:0] ekey;

  always_comb begin
    cap_ext    = CMP_W'(cap_q);
    cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    total_ext  = CMP_W'(total_q);
    bypass     = (cap_q == '0);
    need_evict = !bypass && !hit_q && (total_ext >= cap_eff);
    age_all    = !hit_q && !need_evict;
    slot       = hit_q ? hit_idx_q : (need_evict ? victim_q.idx : free_idx_q);
    old_age    = hit_q ? hit_age_q : victim_q.age;
    total_d    = (!bypass && age_all) ? total_q + OCC_W'(1) : total_q;
    ekey       = need_evict ? victim_q.key : '0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      total_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.commit && !bypass) begin
        total_q <= total_d;
        valid_q[slot] <= 1'b1;
      end
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_key_q <= in_data_i[KEY_W-1:0];
    end
    if (cmd_i.scan) begin
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
      hit_count_q <= hit_count_d;
      hit_age_q   <= hit_age_d;
      free_idx_q  <= free_idx_d;
      for (int g = 0; g < NGROUPS; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
    if (cmd_i.fold) begin
      victim_q <= victim_d;
    end
    if (cmd_i.commit) begin
      out_data_q <= {OCC_OUT_W'(total_d), ekey, need_evict, bypass, hit_q && !bypass};
      if (!bypass) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == slot) begin
            age_q[i] <= '0;
            if (hit_q) begin
              count_q[i] <= (hit_count_q == COUNT_MAX) ? hit_count_q
                                                       : hit_count_q + COUNT_BITS'(1);
            end else begin
              count_q[i] <= COUNT_BITS'(1);
              key_q[i]   <= acc_key_q;
            end
          end else if (valid_q[i] && (age_all || (age_q[i] < old_age))) begin
            age_q[i] <= age_q[i] + AGE_W'(1);
          end
        end
      end
    end
  end

  assign out_data_o = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/core/lfu_cache_replacement_unit.sv =====
// Top level: LFU key directory with oldest-first tiebreak on equal counts.
//
//  channel   dir  signals                          payload (low bit up)
//  s_axis    in   tvalid/tready/tdata[31:0]        access_key
//  m_axis    out  tvalid/tready/tdata[39:0]        hit, bypassed, evicted,
//                                                  evicted_key[31:0], occupancy[4:0]
//  cfg       in   cfg_we_i/cfg_wdata_i[4:0]        capacity
//
// An access runs these steps in order: accept, key match plus per-group victim search,
// victim fold across groups, commit into the directory and the output register.
// The commit step waits while the output register still holds an untaken result;
// a new key is taken while that result waits.
// Reset is asynchronous, active low: all entries invalid, occupancy 0,
// capacity 16. No clearing pass, the directory is usable right after reset.
`default_nettype none
module lfu_cache_replacement_unit
  import lfu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // access keys in
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [31:0] access_key
  // results out
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // [0] hit, [1] bypassed, [2] evicted,
                                                  // [34:3] evicted_key, [39:35] occupancy
  // capacity register
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i
);

  lfu_cmd_t cmd;

  // Sequencer: one access in flight, result held in an output register
  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // Entries, search trees and the update of counts and age ranks
  lfu_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/lfu_checker.sv =====
// Port-level checker for the LFU replacement unit, bound to the top level.
`default_nettype none
`include "lfu_cache_replacement_unit_macros.svh"
module lfu_checker
  import lfu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_o,
  input  logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic hit, bypass, evict, in_xfer;
  logic [KEY_W-1:0]     ekey;
  logic [OCC_OUT_W-1:0] occ;

  assign hit     = m_axis_tdata_o[OUT_HIT_BIT];
  assign bypass  = m_axis_tdata_o[OUT_BYPASS_BIT];
  assign evict   = m_axis_tdata_o[OUT_EVICT_BIT];
  assign ekey    = m_axis_tdata_o[OUT_EKEY_LSB +: KEY_W];
  assign occ     = m_axis_tdata_o[OUT_OCC_LSB +: OCC_OUT_W];
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // result held until taken
  `LFU_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "result dropped or changed under stall")
  // busy right after a key transfer
  `LFU_ASSERT(a_busy_after_xfer, in_xfer |=> !s_axis_tready_o, "accepted a key while an access is in flight")
  // outcome flags exclusive, evicted key zero when nothing was evicted
  `LFU_ASSERT(a_flags, m_axis_tvalid_o |-> !(hit && evict) && !(bypass && (hit || evict)) && (evict || ekey == '0), "inconsistent result flags")
  // occupancy never above the directory size
  `LFU_ASSERT(a_occ_range, m_axis_tvalid_o |-> (occ <= OCC_OUT_W'(ENTRIES)), "occupancy out of range")

endmodule

bind lfu_cache_replacement_unit lfu_checker u_lfu_checker (.*);
`default_nettype wire
